>>> src/ahfe_pkg.sv
package ahfe_pkg;

  localparam int unsigned FRAME_BITS_DEF = 256;
  localparam int unsigned IN_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 4;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       sof;
  } in_item_t;

  typedef struct packed {
    logic [7:0] obyte;
    logic       last;
    logic       ovf;
  } out_item_t;

endpackage

>>> src/ahfe_fifo.sv
module ahfe_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i & ~full_o;
  assign rd_en   = rd_i & ~empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    case ({wr_en, rd_en})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> src/ahfe_front.sv
module ahfe_front import ahfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_i,
  output logic       full,
  input  logic       rd_i,
  output in_item_t   item_o,
  output logic       empty_o
);

  logic     open_q;
  logic     acc;
  in_item_t wr_item;
  logic [$bits(in_item_t)-1:0] rdata;

  assign acc     = push & ~full;
  assign wr_item = '{data: data_byte_i, last: last_in_i, sof: ~open_q};
  assign item_o  = in_item_t'(rdata);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
    end else if (acc) begin
      open_q <= ~last_in_i;
    end
  end

  ahfe_fifo #(
    .WIDTH($bits(in_item_t)),
    .DEPTH(IN_DEPTH)
  ) u_inq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (push),
    .wdata_i(wr_item),
    .full_o (full),
    .rd_i   (rd_i),
    .rdata_o(rdata),
    .empty_o(empty_o)
  );

endmodule

>>> src/ahfe_back.sv
module ahfe_back import ahfe_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_empty_i,
  input  in_item_t  in_item_i,
  output logic      in_rd_o,
  input  logic      out_full_i,
  output logic      out_wr_o,
  output out_item_t out_item_o
);

  localparam int unsigned BitsW = $clog2(FRAME_BITS + 1);
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;
  localparam logic [31:0] HdrWord = 32'h5555_557E;
  localparam logic [7:0]  FlagWord = 8'h7E;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RAMP  = 7'b0000010,
    S_HDR   = 7'b0000100,
    S_DATA  = 7'b0001000,
    S_FCS   = 7'b0010000,
    S_CLOSE = 7'b0100000,
    S_END   = 7'b1000000
  } bstate_e;

  bstate_e          state_q, state_d;
  logic [4:0]       cnt_q, cnt_d;
  logic [7:0]       data_q, data_d;
  logic             last_q, last_d;
  logic             stuff_q, stuff_d;
  logic [2:0]       ones_q, ones_d;
  logic             lvl_q, lvl_d;
  logic [BitsW-1:0] bits_q, bits_d;
  logic [7:0]       shift_q, shift_d;
  logic [2:0]       pcnt_q, pcnt_d;
  logic             trunc_q, trunc_d;
  logic [15:0]      crc_q, crc_d;
  logic [7:0]       pend_q, pend_d;
  logic             pend_v_q, pend_v_d;

  logic       snd, coded, bitv, stf, crc_en, step, byte_done, frame_clr;
  logic       lvl_n, line_bit;
  logic [7:0] byte_w;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    data_d     = data_q;
    last_d     = last_q;
    stuff_d    = stuff_q;
    ones_d     = ones_q;
    lvl_d      = lvl_q;
    bits_d     = bits_q;
    shift_d    = shift_q;
    pcnt_d     = pcnt_q;
    trunc_d    = trunc_q;
    crc_d      = crc_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    in_rd_o    = 1'b0;
    out_wr_o   = 1'b0;
    out_item_o = '{obyte: pend_q, last: 1'b0, ovf: 1'b0};
    snd        = 1'b0;
    coded      = 1'b0;
    bitv       = 1'b0;
    stf        = 1'b0;
    crc_en     = 1'b0;
    step       = 1'b0;
    byte_done  = 1'b0;
    frame_clr  = 1'b0;
    lvl_n      = lvl_q;
    line_bit   = 1'b0;
    byte_w     = '0;

    if (!out_full_i) begin
      unique case (state_q)
        S_IDLE: begin
          if (!in_empty_i) begin
            in_rd_o = 1'b1;
            data_d  = in_item_i.data;
            last_d  = in_item_i.last;
            cnt_d   = '0;
            state_d = in_item_i.sof ? S_RAMP : S_DATA;
          end
        end
        S_RAMP: begin
          snd = 1'b1;
        end
        S_HDR: begin
          snd   = 1'b1;
          coded = 1'b1;
          bitv  = HdrWord[~cnt_q];
        end
        S_DATA: begin
          snd    = 1'b1;
          coded  = 1'b1;
          stf    = 1'b1;
          crc_en = ~stuff_q;
          bitv   = ~stuff_q & data_q[cnt_q[2:0]];
        end
        S_FCS: begin
          snd   = 1'b1;
          coded = 1'b1;
          stf   = 1'b1;
          bitv  = ~stuff_q & ~crc_q[~cnt_q[3:0]];
        end
        S_CLOSE: begin
          snd   = 1'b1;
          coded = 1'b1;
          bitv  = FlagWord[~cnt_q[2:0]];
        end
        S_END: begin
          if (pcnt_q != '0) begin
            if (pend_v_q) begin
              out_wr_o   = 1'b1;
              out_item_o = '{obyte: pend_q, last: 1'b0, ovf: 1'b0};
              pend_v_d   = 1'b0;
            end else begin
              lvl_d  = ~lvl_q;
              byte_w = {shift_q[6:0], ~lvl_q};
              if (pcnt_q == 3'd7) begin
                out_wr_o   = 1'b1;
                out_item_o = '{obyte: byte_w, last: 1'b1, ovf: trunc_q};
                frame_clr  = 1'b1;
              end else begin
                shift_d = byte_w;
                pcnt_d  = pcnt_q + 3'd1;
              end
            end
          end else begin
            out_wr_o   = 1'b1;
            out_item_o = '{obyte: pend_v_q ? pend_q : 8'h00, last: 1'b1, ovf: trunc_q};
            frame_clr  = 1'b1;
          end
        end
        default: state_d = S_IDLE;
      endcase
    end

    if (crc_en) begin
      crc_d = {crc_q[14:0], 1'b0} ^ ((crc_q[15] ^ bitv) ? CrcPoly : 16'h0000);
    end

    if (stf) begin
      if (stuff_q) begin
        stuff_d = 1'b0;
        step    = 1'b1;
      end else if (bitv) begin
        if (ones_q == 3'd4) begin
          stuff_d = 1'b1;
          ones_d  = '0;
        end else begin
          ones_d = ones_q + 3'd1;
          step   = 1'b1;
        end
      end else begin
        ones_d = '0;
        step   = 1'b1;
      end
    end else if (snd) begin
      step = 1'b1;
    end

    if (snd) begin
      lvl_n    = coded ? (bitv ? lvl_q : ~lvl_q) : lvl_q;
      lvl_d    = lvl_n;
      line_bit = coded & lvl_n;
      if (bits_q == BitsW'(FRAME_BITS)) begin
        trunc_d = 1'b1;
      end else begin
        bits_d = bits_q + BitsW'(1);
        byte_w = {shift_q[6:0], line_bit};
        if (pcnt_q == 3'd7) begin
          byte_done = 1'b1;
          shift_d   = '0;
          pcnt_d    = '0;
        end else begin
          shift_d = byte_w;
          pcnt_d  = pcnt_q + 3'd1;
        end
      end
    end

    if (byte_done) begin
      if (last_q) begin
        if (pend_v_q) begin
          out_wr_o   = 1'b1;
          out_item_o = '{obyte: pend_q, last: 1'b0, ovf: 1'b0};
        end
        pend_d   = byte_w;
        pend_v_d = 1'b1;
      end else begin
        out_wr_o   = 1'b1;
        out_item_o = '{obyte: byte_w, last: 1'b0, ovf: 1'b0};
      end
    end

    if (step) begin
      cnt_d = cnt_q + 5'd1;
      unique case (state_q)
        S_RAMP: begin
          if (cnt_q == 5'd7) begin
            state_d = S_HDR;
            cnt_d   = '0;
          end
        end
        S_HDR: begin
          if (cnt_q == 5'd31) begin
            state_d = S_DATA;
            cnt_d   = '0;
          end
        end
        S_DATA: begin
          if (cnt_q == 5'd7) begin
            state_d = last_q ? S_FCS : S_IDLE;
            cnt_d   = '0;
          end
        end
        S_FCS: begin
          if (cnt_q == 5'd15) begin
            state_d = S_CLOSE;
            cnt_d   = '0;
          end
        end
        S_CLOSE: begin
          if (cnt_q == 5'd7) begin
            state_d = S_END;
            cnt_d   = '0;
          end
        end
        default: cnt_d = cnt_q;
      endcase
    end

    if (frame_clr) begin
      state_d  = S_IDLE;
      stuff_d  = 1'b0;
      ones_d   = '0;
      lvl_d    = 1'b0;
      bits_d   = '0;
      shift_d  = '0;
      pcnt_d   = '0;
      trunc_d  = 1'b0;
      crc_d    = CrcInit;
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
    pend_q <= pend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      stuff_q  <= 1'b0;
      ones_q   <= '0;
      lvl_q    <= 1'b0;
      bits_q   <= '0;
      shift_q  <= '0;
      pcnt_q   <= '0;
      trunc_q  <= 1'b0;
      crc_q    <= CrcInit;
      pend_v_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      stuff_q  <= stuff_d;
      ones_q   <= ones_d;
      lvl_q    <= lvl_d;
      bits_q   <= bits_d;
      shift_q  <= shift_d;
      pcnt_q   <= pcnt_d;
      trunc_q  <= trunc_d;
      crc_q    <= crc_d;
      pend_v_q <= pend_v_d;
    end
  end

endmodule

>>> src/ais_hdlc_frame_encoder.sv
// Builds an AIS-style HDLC transmit burst from message bytes and returns the line bits packed
// eight to a byte, first bit in bit 7. Push one payload byte per item, last_in_i on the final
// one; the frame's ramp, training bits, flags, CRC and bit stuffing are added here, and every
// bit after the ramp is NRZI coded. A bit-serial sequencer sends one line bit per clock while the
// output queue is not full; each item is first fetched from the input queue in a step that sends
// no bit. The first byte of a frame also brings 8 ramp and 32 header bits, and the final byte 16
// CRC bits with up to 4 stuffed zeros, the closing flag, padding and the flush of the held final
// byte. A four-item input queue and a four-item output queue let the producer and the consumer
// stall independently; the sequencer pauses while the output queue is full. Frames longer than
// FRAME_BITS line bits are cut off and their final byte has overflow_o set.
module ais_hdlc_frame_encoder import ahfe_pkg::*; #(
  parameter int unsigned FRAME_BITS = FRAME_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       last_out_o,
  output logic       overflow_o
);

  in_item_t  fe_item;
  logic      fe_empty, fe_rd;
  out_item_t be_item, oq_item;
  logic      be_wr, oq_full;
  logic [$bits(out_item_t)-1:0] oq_rdata;

  assign oq_item    = out_item_t'(oq_rdata);
  assign out_byte_o = oq_item.obyte;
  assign last_out_o = oq_item.last;
  assign overflow_o = oq_item.ovf;

  ahfe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .data_byte_i(data_byte_i),
    .last_in_i  (last_in_i),
    .full       (full),
    .rd_i       (fe_rd),
    .item_o     (fe_item),
    .empty_o    (fe_empty)
  );

  ahfe_back #(
    .FRAME_BITS(FRAME_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_empty_i(fe_empty),
    .in_item_i (fe_item),
    .in_rd_o   (fe_rd),
    .out_full_i(oq_full),
    .out_wr_o  (be_wr),
    .out_item_o(be_item)
  );

  ahfe_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (be_wr),
    .wdata_i(be_item),
    .full_o (oq_full),
    .rd_i   (pop),
    .rdata_o(oq_rdata),
    .empty_o(empty)
  );

endmodule

>>> src/ahfe_checker.sv
module ahfe_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       last_out_o,
  input logic       overflow_o
);

  // overflow is reported on the final byte of a frame only
  a_ovf_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && overflow_o) |-> last_out_o)
    else $error("overflow shown on a byte that does not close the frame");

  a_empty_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> (empty && !full))
    else $error("queues not empty right after reset");

  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(last_out_o)
                          && $stable(overflow_o)))
    else $error("waiting item changed or vanished");

  // right after reset, with nothing pushed, no item is waiting at the output
  a_no_spurious_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($past(!rst_ni) && !$past(push)) |-> empty)
    else $error("item appeared without any input");

endmodule

bind ais_hdlc_frame_encoder ahfe_checker u_ahfe_checker (.*);

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ahfe_pkg::*;

  localparam int          FRAME_LIMIT = FRAME_BITS_DEF;
  localparam int          RAMP_BITS   = 8;
  localparam logic [7:0]  TRAIN_OCT   = 8'h55;
  localparam logic [7:0]  FLAG_OCT    = 8'h7E;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam int          TAIL_CYCLES = 200;
  localparam int          CYCLE_LIMIT = 400000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] data_byte = 8'h00;
  logic       last_in = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte;
  logic       last_out;
  logic       overflow;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int err_cnt = 0;
  int cyc_cnt = 0;

  out_item_t line_byte_q[$];
  out_item_t step_bytes[$];

  logic [15:0] fcs_acc;
  int          ones_cnt;
  logic        nrzi_lvl;
  int          line_bits;
  logic [7:0]  pk_shift;
  int          pk_cnt;
  bit          in_frame;
  logic        cut;

  ais_hdlc_frame_encoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .data_byte_i (data_byte),
    .last_in_i   (last_in),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte),
    .last_out_o  (last_out),
    .overflow_o  (overflow)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  initial begin
    while (cyc_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic out_item_t make_byte(input logic [7:0] b, input logic l, input logic o);
    out_item_t r;
    r.obyte = b;
    r.last  = l;
    r.ovf   = o;
    return r;
  endfunction

  task automatic frame_clear();
    fcs_acc   = CRC_INIT;
    ones_cnt  = 0;
    nrzi_lvl  = 1'b0;
    line_bits = 0;
    pk_shift  = 8'h00;
    pk_cnt    = 0;
    in_frame  = 1'b0;
    cut       = 1'b0;
  endtask

  task automatic line_put(input logic b);
    if (line_bits >= FRAME_LIMIT) begin
      cut = 1'b1;
      return;
    end
    line_bits++;
    pk_shift = {pk_shift[6:0], b};
    pk_cnt++;
    if (pk_cnt == 8) begin
      step_bytes.push_back(make_byte(pk_shift, 1'b0, cut));
      pk_cnt   = 0;
      pk_shift = 8'h00;
    end
  endtask

  task automatic nrzi_put(input logic b);
    if (!b) nrzi_lvl = ~nrzi_lvl;
    line_put(nrzi_lvl);
  endtask

  task automatic stuffed_put(input logic b);
    nrzi_put(b);
    if (b) begin
      ones_cnt++;
      if (ones_cnt >= 5) begin
        nrzi_put(1'b0);
        ones_cnt = 0;
      end
    end else begin
      ones_cnt = 0;
    end
  endtask

  task automatic octet_put(input logic [7:0] v);
    for (int k = 7; k >= 0; k--) nrzi_put(v[k]);
  endtask

  task automatic encode_byte(input logic [7:0] d, input logic l);
    logic        fb;
    logic [15:0] fcs_tx;
    step_bytes.delete();
    if (!in_frame) begin
      frame_clear();
      in_frame = 1'b1;
      repeat (RAMP_BITS) line_put(1'b0);
      repeat (3) octet_put(TRAIN_OCT);
      octet_put(FLAG_OCT);
      ones_cnt = 0;
    end
    for (int k = 0; k < 8; k++) begin
      fb      = fcs_acc[15] ^ d[k];
      fcs_acc = fcs_acc << 1;
      if (fb) fcs_acc ^= CRC_POLY;
      stuffed_put(d[k]);
    end
    if (l) begin
      fcs_tx = ~fcs_acc;
      for (int k = 15; k >= 0; k--) stuffed_put(fcs_tx[k]);
      octet_put(FLAG_OCT);
      if (pk_cnt != 0) begin
        while (pk_cnt < 8) begin
          nrzi_lvl = ~nrzi_lvl;
          pk_shift = {pk_shift[6:0], nrzi_lvl};
          pk_cnt++;
        end
        step_bytes.push_back(make_byte(pk_shift, 1'b1, cut));
      end else if (step_bytes.size() > 0) begin
        step_bytes[step_bytes.size() - 1].last = 1'b1;
        step_bytes[step_bytes.size() - 1].ovf  = cut;
      end else begin
        step_bytes.push_back(make_byte(8'h00, 1'b1, cut));
      end
      frame_clear();
    end
    foreach (step_bytes[i]) line_byte_q.push_back(step_bytes[i]);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push      <= 1'b1;
    data_byte <= d;
    last_in   <= l;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    encode_byte(d, l);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (line_byte_q.size() == 0) begin
          $error("unexpected item: out_byte %0h last_out %0b overflow %0b",
                 out_byte, last_out, overflow);
          err_cnt++;
        end else begin
          if (out_byte !== line_byte_q[0].obyte) begin
            $error("out_byte: expected %0h, actual %0h", line_byte_q[0].obyte, out_byte);
            err_cnt++;
          end
          if (last_out !== line_byte_q[0].last) begin
            $error("last_out: expected %0b, actual %0b", line_byte_q[0].last, last_out);
            err_cnt++;
          end
          if (overflow !== line_byte_q[0].ovf) begin
            $error("overflow: expected %0b, actual %0b", line_byte_q[0].ovf, overflow);
            err_cnt++;
          end
          void'(line_byte_q.pop_front());
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic test_single_byte_frames();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h7E, 1'b1);
    send_byte(8'h1F, 1'b1);
  endtask

  task automatic test_stuffing_runs();
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h3E, 1'b1);
  endtask

  task automatic test_overflow();
    // frame fills FRAME_BITS exactly, final byte leaves nothing: end marker
    for (int i = 0; i < 27; i++) send_byte(8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    for (int i = 0; i < 30; i++) send_byte(8'hFF, i == 29);
  endtask

  task automatic test_random_frames(input int n_items, input int s_idle, input int r_idle);
    int          sent;
    int          len;
    logic [7:0]  d;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 34) : $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        d = ($urandom_range(0, 4) == 0) ? 8'hFF : 8'($urandom_range(0, 255));
        send_byte(d, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    frame_clear();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 38;
    recv_idle_pct = 66;
    test_single_byte_frames();
    test_stuffing_runs();
    test_overflow();
    test_random_frames(96, 38, 66);
    test_random_frames(96, 66, 38);
    test_random_frames(96, 0, 0);
    push <= 1'b0;
    while (line_byte_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && line_byte_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
